/* rtl/wbps_pkg.sv */
// shared types and constants for the wildcard byte pattern scanner
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int PATTERN_SLOTS = 16;

  localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;

  typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic        end_of_data;
    logic        none_found;
  } result_t;

endpackage

/* rtl/wbps_cell.sv */
// one window cell: holds a stream byte and compares its incoming byte with its pattern byte
`timescale 1ns / 1ps

module wbps_cell #(
  parameter int IDX = 0,
  parameter int LW  = 5
) (
  input  logic                clk,
  input  logic                shift,
  input  logic [7:0]          din,
  input  wbps_pkg::pattern_t  pattern,
  input  logic [LW-1:0]       len_eff,
  output logic [7:0]          dout,
  output logic                ok
);

  logic          active;
  logic [LW-1:0] pidx;
  logic [7:0]    pat;

  assign active = LW'(IDX) < len_eff;
  assign pidx   = len_eff - LW'(IDX) - LW'(1);
  assign pat    = (active && (pidx < LW'(wbps_pkg::PATTERN_SLOTS))) ?
                  pattern[pidx[3:0]] : 8'h00;
  assign ok     = (pat == 8'h00) || (din == pat);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

/* rtl/wbps_track.sv */
// stream position, match start window and result assembly
`timescale 1ns / 1ps

module wbps_track #(
  parameter int OFFSET_BITS = 32,
  parameter int LW          = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                last,
  input  logic                all_ok,
  input  logic [LW-1:0]       len_eff,
  output wbps_pkg::result_t   res,
  output logic                emit
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] nas;
  logic                   any_seen;
  logic [OFFSET_BITS-1:0] lm1;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   hit;

  assign lm1     = OFFSET_BITS'(len_eff) - OFFSET_BITS'(1);
  assign start   = pos - lm1;
  assign hit     = all_ok && (pos >= lm1) && (start >= nas);
  assign pos_inc = (pos == POS_MAX) ? pos : pos + OFFSET_BITS'(1);
  assign emit    = hit || last;

  always_comb begin
    res.match_found  = hit;
    res.match_offset = hit ? 32'(start) : 32'd0;
    res.end_of_data  = last;
    res.none_found   = last && !(any_seen || hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      nas      <= '0;
      any_seen <= 1'b0;
    end else if (accept) begin
      if (last) begin
        pos      <= '0;
        nas      <= '0;
        any_seen <= 1'b0;
      end else begin
        pos <= pos_inc;
        if (hit) begin
          nas      <= pos_inc;
          any_seen <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/wildcard_byte_pattern_scanner.sv */
// top level of the wildcard byte pattern scanner
// Takes one byte per clock and reports, in the cycle after the byte that ends it,
// each non-overlapping match of a pattern of up to 16 bytes (pattern byte zero
// matches anything) with its start offset; the last byte of a stream always
// gives a word with tlast set (none-found if no match), then the position state
// clears. A row of MAX_PATTERN_BYTES cells shifts the window and compares all
// pattern bytes in parallel, so the sustained rate is one byte per cycle;
// s_tready only drops while a result word is held and m_tready is low.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // match_offset
  output logic        m_tlast,   // end_of_data
  output logic [1:0]  m_tuser    // match_found, none_found
);

  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int LW    = (LEN_W > 5) ? LEN_W : 5;

  logic [63:0]        pattern_bytes_low;
  logic [63:0]        pattern_bytes_high;
  logic [4:0]         pattern_length;
  logic               cfg_wr;
  wbps_pkg::pattern_t pattern;
  logic [LW-1:0]      len_eff;
  logic [LW-1:0]      len_raw;

  logic [7:0]                   win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_ok;
  logic                         accept;
  wbps_pkg::result_t            res;
  logic                         emit;
  logic                         out_valid;
  wbps_pkg::result_t            out_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      pattern_length     <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        wbps_pkg::REG_PATTERN_LOW:  pattern_bytes_low  <= pwdata;
        wbps_pkg::REG_PATTERN_HIGH: pattern_bytes_high <= pwdata;
        wbps_pkg::REG_PATTERN_LEN:  pattern_length     <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      wbps_pkg::REG_PATTERN_LOW:  prdata = pattern_bytes_low;
      wbps_pkg::REG_PATTERN_HIGH: prdata = pattern_bytes_high;
      wbps_pkg::REG_PATTERN_LEN:  prdata = {59'd0, pattern_length};
      default:                    prdata = 64'd0;
    endcase
  end

  assign pattern = {pattern_bytes_high, pattern_bytes_low};
  assign len_raw = LW'(pattern_length);

  always_comb begin
    priority if (pattern_length == 5'd0) begin
      len_eff = LW'(1);
    end else if (len_raw > LW'(MAX_PATTERN_BYTES)) begin
      len_eff = LW'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = len_raw;
    end
  end

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [7:0] din;
    if (k == 0) begin : g_head
      assign din = s_tdata;
    end else begin : g_link
      assign din = win[k-1];
    end
    wbps_cell #(
      .IDX (k),
      .LW  (LW)
    ) u_cell (
      .clk     (clk),
      .shift   (accept),
      .din     (din),
      .pattern (pattern),
      .len_eff (len_eff),
      .dout    (win[k]),
      .ok      (cell_ok[k])
    );
  end

  wbps_track #(
    .OFFSET_BITS (OFFSET_BITS),
    .LW          (LW)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .last    (s_tlast),
    .all_ok  (&cell_ok),
    .len_eff (len_eff),
    .res     (res),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.match_offset;
  assign m_tlast  = out_res.end_of_data;
  assign m_tuser  = {out_res.none_found, out_res.match_found};

endmodule

/* rtl/wbps_checker.sv */
// port-level checks for the wildcard byte pattern scanner and its bind
`timescale 1ns / 1ps

module wbps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  // input side only stalls while a word is held downstream
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output occupancy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // the last byte of a stream always closes it in the next cycle
  a_close: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid && m_tlast)
    else $error("stream end not reported");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("output word without an accepted byte");

  // a word that does not close the stream is a match
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[0] && !m_tuser[1])
    else $error("mid-stream word without a match");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
